// ===== hdl/vflt_pkg.sv =====
`default_nettype none
package vflt_pkg;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 25;
	localparam int B_BITS        = 4;
	localparam int GOP_BITS      = 11;
	localparam int NTR_BITS      = 25;
	localparam int PL_OUT_BITS   = 16;
	localparam int FL_OUT_BITS   = 25;
	localparam int CNT_BITS      = 32;

	localparam logic [CFG_IDX_BITS-1:0] CFG_B_FRAMES = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GOP      = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NTR      = 2'd2;

	localparam logic [1:0] FT_I   = 2'd0;
	localparam logic [1:0] FT_IDR = 2'd1;
	localparam logic [1:0] FT_P   = 2'd2;
	localparam logic [1:0] FT_B   = 2'd3;

	// divider jobs, run in this order
	localparam logic [1:0] DIV_QUOT = 2'd0;
	localparam logic [1:0] DIV_GOP  = 2'd1;
	localparam logic [1:0] DIV_WRAP = 2'd2;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic       div_capture;
		logic [1:0] div_sel;
		logic       update;
	} vflt_cmd_t;

	typedef struct packed {
		logic div_done;
	} vflt_status_t;

endpackage
`default_nettype wire

// ===== hdl/vflt_div.sv =====
`default_nettype none
module vflt_div #(
	parameter int W  = 26,
	parameter int DW = 25
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [W-1:0]  dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [W-1:0]       quotient,
	output logic [DW-1:0]      remainder
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   sh;
	logic          ge;

	assign sh = {rem_q, quo_q[W-1]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? DW'(sh - {1'b0, dvs_q}) : DW'(sh);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ===== hdl/vflt_ctrl.sv =====
`default_nettype none
module vflt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire vflt_pkg::vflt_status_t status,
	output vflt_pkg::vflt_cmd_t        cmd
);
	import vflt_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;
	localparam logic [1:0] S_UPD   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] phase_q;
	logic       ov_q;
	logic       upd;

	assign upd      = (state_q == S_UPD) && (!ov_q || out_ready);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.load        = in_valid && (state_q == S_IDLE);
		cmd.div_start   = (state_q == S_START);
		cmd.div_capture = (state_q == S_WAIT) && status.div_done;
		cmd.div_sel     = phase_q;
		cmd.update      = upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= DIV_QUOT;
			ov_q    <= 1'b0;
		end else begin
			if (upd)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
						phase_q <= DIV_QUOT;
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (status.div_done) begin
						if (phase_q == DIV_WRAP) begin
							state_q <= S_UPD;
						end else begin
							phase_q <= phase_q + 1'b1;
							state_q <= S_START;
						end
					end
				end
				S_UPD: begin
					// hold until the previous result has gone
					if (upd)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
endmodule
`default_nettype wire

// ===== hdl/vflt_dp.sv =====
`default_nettype none
module vflt_dp #(
	parameter int SEQ_BITS   = 16,
	parameter int FRAME_BITS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire vflt_pkg::vflt_cmd_t                 cmd,
	output vflt_pkg::vflt_status_t                   status,
	input  wire logic                                cfg_we,
	input  wire logic [vflt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [vflt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic [SEQ_BITS-1:0]                 seq_number,
	input  wire logic                                fragment_start,
	input  wire logic                                fragment_end,
	input  wire logic [FRAME_BITS-1:0]               frame_number,
	input  wire logic [1:0]                          frame_type,
	input  wire logic                                warmup_over,
	output logic                                     tracking_active,
	output logic [vflt_pkg::PL_OUT_BITS-1:0]         packets_lost_now,
	output logic [vflt_pkg::FL_OUT_BITS-1:0]         frames_lost_now,
	output logic [vflt_pkg::CNT_BITS-1:0]            packets_received_total,
	output logic [vflt_pkg::CNT_BITS-1:0]            packets_lost_total,
	output logic [vflt_pkg::CNT_BITS-1:0]            frames_received_total,
	output logic [vflt_pkg::CNT_BITS-1:0]            frames_discarded_total
);
	import vflt_pkg::*;

	localparam int EW = FRAME_BITS + 2;
	localparam int SW = ((EW > CNT_BITS) ? EW : CNT_BITS) + 1;
	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

	// configuration
	logic [B_BITS-1:0]   b_q;
	logic [GOP_BITS-1:0] gop_q;
	logic [NTR_BITS-1:0] ntr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q   <= B_BITS'(2);
			gop_q <= GOP_BITS'(12);
			ntr_q <= NTR_BITS'(16777216);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_B_FRAMES: b_q   <= cfg_data[B_BITS-1:0];
				CFG_GOP:      gop_q <= cfg_data[GOP_BITS-1:0];
				CFG_NTR:      ntr_q <= cfg_data[NTR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// captured packet
	logic [SEQ_BITS-1:0]   seq_q;
	logic                  fs_q;
	logic                  fe_q;
	logic [FRAME_BITS-1:0] f_q;
	logic [1:0]            type_q;
	logic                  wu_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q  <= seq_number;
			fs_q   <= fragment_start;
			fe_q   <= fragment_end;
			f_q    <= frame_number;
			type_q <= frame_type;
			wu_q   <= warmup_over;
		end
	end

	// tracking state
	logic                  warm_q;
	logic [SEQ_BITS-1:0]   last_seq_q;
	logic signed [EW-1:0]  lgi_q;
	logic signed [EW-1:0]  lgp_q;
	logic [FRAME_BITS-1:0] cur_frame_q;
	logic signed [EW-1:0]  cur_enc_q;
	logic                  fin_q;
	logic                  disc_q;
	logic [CNT_BITS-1:0]   prc_q;
	logic [CNT_BITS-1:0]   plc_q;
	logic [CNT_BITS-1:0]   frc_q;
	logic [CNT_BITS-1:0]   fdc_q;

	logic signed [EW-1:0] f_s;
	logic signed [EW-1:0] b_s;
	logic signed [EW-1:0] enc;
	logic signed [EW-1:0] ce1;
	logic [EW-1:0]        ce1_abs;

	assign f_s     = $signed({2'b00, f_q});
	assign b_s     = $signed(EW'(b_q));
	assign ce1     = cur_enc_q + EW'(1);
	assign ce1_abs = ce1[EW-1] ? EW'(-ce1) : EW'(ce1);

	always_comb begin
		case (type_q)
			FT_I, FT_IDR: enc = (f_q == '0) ? '0 : f_s - b_s;
			FT_P:         enc = f_s - b_s;
			default:      enc = f_s + EW'(1);
		endcase
	end

	// divider jobs
	logic [GOP_BITS-1:0] gop_eff;
	logic [NTR_BITS-1:0] ntr_eff;
	logic [EW-1:0]       dvd;
	logic [NTR_BITS-1:0] dvs;
	logic                div_done;
	logic [EW-1:0]       quo;
	logic [NTR_BITS-1:0] rem;

	logic [EW-1:0]        lastd_q;
	logic [EW-1:0]        nextd_q;
	logic                 gop_zero_q;
	logic signed [EW-1:0] tm_q;
	logic [EW-1:0]        lastd;
	logic [EW-1:0]        rem_w;

	assign gop_eff = (gop_q == '0) ? GOP_BITS'(1) : gop_q;
	assign ntr_eff = (ntr_q == '0) ? NTR_BITS'(1) : ntr_q;

	always_comb begin
		case (cmd.div_sel)
			DIV_QUOT: begin
				dvd = EW'(f_q);
				dvs = NTR_BITS'(b_q) + NTR_BITS'(1);
			end
			DIV_GOP: begin
				dvd = nextd_q;
				dvs = NTR_BITS'(gop_eff);
			end
			default: begin
				dvd = ce1_abs;
				dvs = ntr_eff;
			end
		endcase
	end

	vflt_div #(.W(EW), .DW(NTR_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dvd),
		.divisor   (dvs),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign status.div_done = div_done;
	assign lastd = EW'(quo * (EW'(b_q) + EW'(1)));
	assign rem_w = EW'(rem);

	always_ff @(posedge clk) begin
		if (cmd.div_capture) begin
			case (cmd.div_sel)
				DIV_QUOT: begin
					lastd_q <= lastd;
					nextd_q <= lastd + EW'(b_q) + EW'(1);
				end
				DIV_GOP: gop_zero_q <= (rem == '0);
				default: tm_q <= ce1[EW-1] ? -$signed(rem_w) : $signed(rem_w);
			endcase
		end
	end

	function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
			input logic [SW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + b;
		return (s > SW'(CNT_MAX)) ? CNT_MAX : s[CNT_BITS-1:0];
	endfunction

	// next state
	logic                  n_warm;
	logic [SEQ_BITS-1:0]   n_last_seq;
	logic signed [EW-1:0]  n_lgi;
	logic signed [EW-1:0]  n_lgp;
	logic [FRAME_BITS-1:0] n_cur_frame;
	logic signed [EW-1:0]  n_cur_enc;
	logic                  n_fin;
	logic                  n_disc;
	logic [CNT_BITS-1:0]   n_prc;
	logic [CNT_BITS-1:0]   n_plc;
	logic [CNT_BITS-1:0]   n_frc;
	logic [CNT_BITS-1:0]   n_fdc;
	logic [SEQ_BITS-1:0]   pl;
	logic [EW-1:0]         fl;
	logic                  ok;
	logic signed [EW-1:0]  ref_f;
	logic signed [EW-1:0]  lastd_s;
	logic signed [EW-1:0]  nextd_s;
	logic                  is_ref;

	assign ref_f   = f_s - b_s - EW'(1);
	assign lastd_s = $signed(lastd_q);
	assign nextd_s = $signed(nextd_q);
	assign is_ref  = (type_q == FT_I) || (type_q == FT_IDR);

	always_comb begin
		n_warm      = warm_q;
		n_last_seq  = last_seq_q;
		n_lgi       = lgi_q;
		n_lgp       = lgp_q;
		n_cur_frame = cur_frame_q;
		n_cur_enc   = cur_enc_q;
		n_fin       = fin_q;
		n_disc      = disc_q;
		n_prc       = prc_q;
		n_plc       = plc_q;
		n_frc       = frc_q;
		n_fdc       = fdc_q;
		pl          = '0;
		fl          = '0;
		ok          = 1'b0;
		if (!warm_q) begin
			if (wu_q && is_ref && fs_q) begin
				n_last_seq  = seq_q;
				n_lgp       = (f_q != '0) ? ref_f : '1;
				n_cur_frame = f_q;
				n_cur_enc   = enc;
				if (fe_q) begin
					n_fin = 1'b1;
					n_lgi = f_s;
					n_frc = sat_add(frc_q, SW'(1));
				end else begin
					n_disc = 1'b0;
					n_fin  = 1'b0;
					n_lgi  = '1;
				end
				n_prc  = sat_add(prc_q, SW'(1));
				n_warm = 1'b1;
			end
		end else begin
			if (seq_q != SEQ_BITS'(last_seq_q + SEQ_BITS'(1))) begin
				pl = (seq_q > last_seq_q) ? SEQ_BITS'(seq_q - last_seq_q) : SEQ_BITS'(1);
				if (enc > tm_q && enc > cur_enc_q)
					fl = EW'(enc - cur_enc_q - EW'(1));
				if (!fin_q)
					fl = fl + EW'(1);
				if (!fs_q)
					n_disc = 1'b1;
			end
			n_last_seq = seq_q;
			if (fs_q) begin
				case (type_q)
					FT_I, FT_IDR: ok = 1'b1;
					FT_P:         ok = (lgi_q == ref_f) || (lgp_q == ref_f);
					default: begin
						if (gop_zero_q)
							ok = (lgp_q == lastd_s) && (lgi_q == nextd_s);
						else
							ok = (lgp_q == nextd_s);
					end
				endcase
				if (ok) begin
					if (type_q == FT_P)
						n_disc = 1'b0;
					if (fe_q) begin
						n_fin = 1'b1;
						if (is_ref)
							n_lgi = f_s;
						else if (type_q == FT_P)
							n_lgp = f_s;
						n_frc = sat_add(frc_q, SW'(1));
					end else begin
						n_disc = 1'b0;
						n_fin  = 1'b0;
					end
				end else begin
					n_disc = 1'b1;
					n_fin  = fe_q;
					if (fe_q)
						fl = fl + EW'(1);
				end
				n_cur_frame = f_q;
				n_cur_enc   = enc;
			end else if (fe_q) begin
				if (!n_disc) begin
					if (is_ref)
						n_lgi = $signed({2'b00, cur_frame_q});
					else if (type_q == FT_P)
						n_lgp = $signed({2'b00, cur_frame_q});
					n_frc = sat_add(frc_q, SW'(1));
				end else begin
					fl = fl + EW'(1);
				end
				n_fin = 1'b1;
			end
			n_prc = sat_add(prc_q, SW'(1));
			n_plc = sat_add(plc_q, SW'(pl));
			n_fdc = sat_add(fdc_q, SW'(fl));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q      <= 1'b0;
			last_seq_q  <= '0;
			lgi_q       <= '1;
			lgp_q       <= '1;
			cur_frame_q <= '0;
			cur_enc_q   <= '0;
			fin_q       <= 1'b1;
			disc_q      <= 1'b0;
			prc_q       <= '0;
			plc_q       <= '0;
			frc_q       <= '0;
			fdc_q       <= '0;
		end else if (cmd.update) begin
			warm_q      <= n_warm;
			last_seq_q  <= n_last_seq;
			lgi_q       <= n_lgi;
			lgp_q       <= n_lgp;
			cur_frame_q <= n_cur_frame;
			cur_enc_q   <= n_cur_enc;
			fin_q       <= n_fin;
			disc_q      <= n_disc;
			prc_q       <= n_prc;
			plc_q       <= n_plc;
			frc_q       <= n_frc;
			fdc_q       <= n_fdc;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			tracking_active        <= n_warm;
			packets_lost_now       <= PL_OUT_BITS'(pl);
			frames_lost_now        <= FL_OUT_BITS'(fl);
			packets_received_total <= n_prc;
			packets_lost_total     <= n_plc;
			frames_received_total  <= n_frc;
			frames_discarded_total <= n_fdc;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/video_frame_loss_tracker.sv =====
// Each packet makes three passes through the one-bit-per-cycle divider between input
// transfer and the result register.
// One packet is processed at a time; a new packet is taken once the previous one has
// been registered, even while that result still waits in the output register.
// Reset (arst_n low) clears tracking state, counters and configuration to defaults.
`default_nettype none
module video_frame_loss_tracker #(
	parameter int SEQ_BITS   = 16,
	parameter int FRAME_BITS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [vflt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [vflt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [SEQ_BITS-1:0]                 seq_number,
	input  wire logic                                fragment_start,
	input  wire logic                                fragment_end,
	input  wire logic [FRAME_BITS-1:0]               frame_number,
	input  wire logic [1:0]                          frame_type,
	input  wire logic                                warmup_over,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     tracking_active,
	output logic [vflt_pkg::PL_OUT_BITS-1:0]         packets_lost_now,
	output logic [vflt_pkg::FL_OUT_BITS-1:0]         frames_lost_now,
	output logic [vflt_pkg::CNT_BITS-1:0]            packets_received_total,
	output logic [vflt_pkg::CNT_BITS-1:0]            packets_lost_total,
	output logic [vflt_pkg::CNT_BITS-1:0]            frames_received_total,
	output logic [vflt_pkg::CNT_BITS-1:0]            frames_discarded_total
);
	import vflt_pkg::*;

	vflt_cmd_t    cmd;
	vflt_status_t status;

	assign cfg_ready = 1'b1;

	vflt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	vflt_dp #(.SEQ_BITS(SEQ_BITS), .FRAME_BITS(FRAME_BITS)) u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.status                 (status),
		.cfg_we                 (cfg_valid),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.seq_number             (seq_number),
		.fragment_start         (fragment_start),
		.fragment_end           (fragment_end),
		.frame_number           (frame_number),
		.frame_type             (frame_type),
		.warmup_over            (warmup_over),
		.tracking_active        (tracking_active),
		.packets_lost_now       (packets_lost_now),
		.frames_lost_now        (frames_lost_now),
		.packets_received_total (packets_received_total),
		.packets_lost_total     (packets_lost_total),
		.frames_received_total  (frames_received_total),
		.frames_discarded_total (frames_discarded_total)
	);
endmodule
`default_nettype wire

// ===== hdl/vflt_checker.sv =====
`default_nettype none
module vflt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        tracking_active,
	input wire logic [15:0] packets_lost_now,
	input wire logic [24:0] frames_lost_now,
	input wire logic [31:0] packets_received_total
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packets_received_total))
		else $error("result changed while stalled");

	// one packet at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second packet taken while busy");

	a_idle_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tracking_active |-> packets_lost_now == 16'd0 && frames_lost_now == 25'd0)
		else $error("loss reported before tracking started");
endmodule

bind video_frame_loss_tracker vflt_checker u_vflt_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.in_valid               (in_valid),
	.in_ready               (in_ready),
	.out_valid              (out_valid),
	.out_ready              (out_ready),
	.tracking_active        (tracking_active),
	.packets_lost_now       (packets_lost_now),
	.frames_lost_now        (frames_lost_now),
	.packets_received_total (packets_received_total)
);
`default_nettype wire
